// ===== hw/rtl/wgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Shared constants, action codes, and the structs for cell commands, links and the result word.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int MAX_MASK_LEN = 32;
    localparam int CHAR_W       = 16;
    localparam int ACTION_W     = 2;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [CHAR_W-1:0] GLOB_STAR = 16'h002A;
    localparam logic [CHAR_W-1:0] GLOB_ANY  = 16'h003F;

    localparam logic [ACTION_W-1:0] ACT_APPEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SUBJECT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_END     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

    typedef struct packed {
        logic              append;
        logic              consume;
        logic              rearm;
        logic              clear;
        logic [CHAR_W-1:0] ch;
    } wgm_cmd_t;

    typedef struct packed {
        logic used;
        logic carry;
        logic step;
    } wgm_link_t;

    typedef struct packed {
        logic mask_overflow;
        logic matched;
    } wgm_result_t;

endpackage

// ===== hw/rtl/wgm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard glob matcher cell
// Holds one mask character and the active bit of the position in front of it.
// ----------------------------------------------------------------------------
module wgm_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  wgm_pkg::wgm_cmd_t  cmd,
    input  logic               home,
    input  wgm_pkg::wgm_link_t link_in,
    output wgm_pkg::wgm_link_t link_out,
    output logic               hit
);

    logic [wgm_pkg::CHAR_W-1:0] ch_reg;
    logic                       used_reg;
    logic                       used_next;
    logic                       act_reg;
    logic                       act_next;
    logic                       closed;
    logic                       is_star;
    logic                       is_step;
    logic                       write_en;

    assign closed   = act_reg | link_in.carry;
    assign is_star  = used_reg & (ch_reg == wgm_pkg::GLOB_STAR);
    assign is_step  = used_reg & (ch_reg != wgm_pkg::GLOB_STAR)
                      & ((ch_reg == wgm_pkg::GLOB_ANY) | (ch_reg == cmd.ch));
    assign write_en = cmd.append & link_in.used & ~used_reg;

    assign link_out.used  = used_reg;
    assign link_out.carry = closed & is_star;
    assign link_out.step  = closed & is_step;
    assign hit            = closed & link_in.used & ~used_reg;

    always_comb begin
        used_next = used_reg;
        if (cmd.clear) begin
            used_next = 1'b0;
        end else if (write_en) begin
            used_next = 1'b1;
        end
    end

    always_comb begin
        act_next = act_reg;
        if (cmd.rearm) begin
            act_next = home;
        end else if (cmd.consume) begin
            act_next = (closed & is_star) | link_in.step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            act_reg  <= home;
        end else begin
            used_reg <= used_next;
            act_reg  <= act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (write_en) begin
            ch_reg <= cmd.ch;
        end
    end

endmodule

// ===== hw/rtl/wgm_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard glob matcher output register
// Holds one result word until the master side takes it.
// ----------------------------------------------------------------------------
module wgm_out_reg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  wgm_pkg::wgm_result_t                result,
    output logic                                space,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wgm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    logic                 valid_reg;
    logic                 valid_next;
    wgm_pkg::wgm_result_t result_reg;

    assign space    = ~valid_reg | m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(wgm_pkg::OUT_TDATA_W - 2){1'b0}}, result_reg.mask_overflow,
                       result_reg.matched};

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ===== hw/rtl/wildcard_glob_matcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Matches a stream of 16-bit subject characters against a stored mask with
// '*' and '?' wildcards, using a row of position cells.
//
// Channel   Dir  tdata                  tuser
// s_        in   [15:0] character       [1:0] action
// m_        out  [0] matched,           none
//                [1] mask_overflow
//
// Every word is taken when accepted, and a new word can follow straight after it while s_tready is high.
// The end-of-subject word loads the result into the output register, which
// is read while further input words are accepted.
// The critical path is the star-closure chain through the 32 cells.
// Input stalls only while a result waits in the output register and
// m_tready is low. Reset empties the mask and rearms the automaton at once.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [15:0] character
    input  logic [1:0]  s_tuser,  // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // [0] matched, [1] mask_overflow
);

    localparam int N = wgm_pkg::MAX_MASK_LEN;

    wgm_pkg::wgm_cmd_t    cmd;
    wgm_pkg::wgm_link_t   links [0:N];
    wgm_pkg::wgm_result_t result;
    logic [N-1:0]         hits;
    logic [N-1:0]         used_vec;
    logic                 accept;
    logic                 space;
    logic                 end_word;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 last_closed;
    logic                 last_hit;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = space;
    assign end_word = accept & (s_tuser == wgm_pkg::ACT_END);

    assign cmd.append  = accept & (s_tuser == wgm_pkg::ACT_APPEND);
    assign cmd.consume = accept & (s_tuser == wgm_pkg::ACT_SUBJECT);
    assign cmd.clear   = accept & (s_tuser == wgm_pkg::ACT_CLEAR);
    assign cmd.rearm   = end_word | cmd.clear;
    assign cmd.ch      = s_tdata;

    assign links[0] = '{used: 1'b1, carry: 1'b0, step: 1'b0};

    for (genvar k = 0; k < N; k++) begin : g_cell
        wgm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .home     (k == 0),
            .link_in  (links[k]),
            .link_out (links[k+1]),
            .hit      (hits[k])
        );
        assign used_vec[k] = links[k+1].used;
    end

    assign last_closed = last_reg | links[N].carry;
    assign last_hit    = last_closed & links[N].used;

    assign result.matched       = ((|hits) | last_hit) & ~ovf_reg;
    assign result.mask_overflow = ovf_reg;

    always_comb begin
        ovf_next = ovf_reg;
        if (cmd.clear) begin
            ovf_next = 1'b0;
        end else if (cmd.append & links[N].used) begin
            ovf_next = 1'b1;
        end
    end

    always_comb begin
        last_next = last_reg;
        if (cmd.rearm) begin
            last_next = 1'b0;
        end else if (cmd.consume) begin
            last_next = links[N].step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg  <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            ovf_reg  <= ovf_next;
            last_reg <= last_next;
        end
    end

    wgm_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (end_word),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The filled cells always form an unbroken run from cell zero.
    a_used_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ((used_vec & (used_vec + 1'b1)) == '0))
        else $error("mask cells are not filled in order");

    a_ovf_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("match reported with overflowed mask");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        end_word |=> m_tvalid)
        else $error("end of subject gave no result word");

    a_clear_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (!ovf_reg && !last_reg && !used_vec[0]))
        else $error("clear left state behind");

endmodule

// ===== test/wildcard_glob_matcher_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard glob matcher testbench
// Streams mask and subject words into the matcher, computes the expected
// match result for each end-of-subject word with a position-set predictor,
// and compares every result word field by field, with random idle cycles on
// the input channel and back-pressure on the result channel.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top_tb;

    localparam int ITEM_TARGET    = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    class glob_scoreboard;
        logic [wgm_pkg::CHAR_W-1:0]     mask_chars [wgm_pkg::MAX_MASK_LEN];
        int unsigned                    mask_len;
        logic [wgm_pkg::MAX_MASK_LEN:0] live;
        bit                             overflow;
        wgm_pkg::wgm_result_t           expected_results [$];
        int                             errors;

        function new();
            mask_len = 0;
            overflow = 1'b0;
            errors   = 0;
            rearm();
        endfunction

        function void rearm();
            live    = '0;
            live[0] = 1'b1;
        endfunction

        // A set position in front of a star also reaches the next position.
        function void close_stars();
            for (int i = 0; i < mask_len; i++) begin
                if (live[i] && mask_chars[i] == wgm_pkg::GLOB_STAR) begin
                    live[i+1] = 1'b1;
                end
            end
        endfunction

        function void step_subject(logic [wgm_pkg::CHAR_W-1:0] ch);
            logic [wgm_pkg::MAX_MASK_LEN:0] nxt;
            nxt = '0;
            close_stars();
            for (int i = 0; i < mask_len; i++) begin
                if (live[i]) begin
                    if (mask_chars[i] == wgm_pkg::GLOB_STAR) begin
                        nxt[i] = 1'b1;
                    end else if (mask_chars[i] == wgm_pkg::GLOB_ANY
                                 || mask_chars[i] == ch) begin
                        nxt[i+1] = 1'b1;
                    end
                end
            end
            live = nxt;
        endfunction

        function void note_word(logic [wgm_pkg::ACTION_W-1:0] act,
                                logic [wgm_pkg::CHAR_W-1:0] ch);
            wgm_pkg::wgm_result_t res;
            case (act)
                wgm_pkg::ACT_APPEND: begin
                    if (mask_len < wgm_pkg::MAX_MASK_LEN) begin
                        mask_chars[mask_len] = ch;
                        mask_len++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                wgm_pkg::ACT_SUBJECT: begin
                    step_subject(ch);
                end
                wgm_pkg::ACT_END: begin
                    close_stars();
                    res.matched       = live[mask_len] && !overflow;
                    res.mask_overflow = overflow;
                    expected_results.push_back(res);
                    rearm();
                end
                default: begin
                    mask_len = 0;
                    overflow = 1'b0;
                    rearm();
                end
            endcase
        endfunction

        function void check_result(wgm_pkg::wgm_result_t got);
            wgm_pkg::wgm_result_t exp_res;
            if (expected_results.size() == 0) begin
                $error("Result word arrived with no result pending.");
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (got.matched !== exp_res.matched) begin
                $error("matched: expected %0d, got %0d", exp_res.matched, got.matched);
                errors++;
            end
            if (got.mask_overflow !== exp_res.mask_overflow) begin
                $error("mask_overflow: expected %0d, got %0d",
                       exp_res.mask_overflow, got.mask_overflow);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;  // [15:0] character
    logic [1:0]  s_tuser;  // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;  // [0] matched, [1] mask_overflow

    glob_scoreboard sb;
    int             sent_words = 0;
    int             idle_cycles = 0;
    bit             calm = 1'b0;

    wildcard_glob_matcher_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [wgm_pkg::CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return wgm_pkg::GLOB_STAR;
        end else if (r < 40) begin
            return wgm_pkg::GLOB_ANY;
        end else if (r < 85) begin
            return 16'h0061 + 16'($urandom_range(0, 1));
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic int pick_mask_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) begin
            return $urandom_range(0, 8);
        end else if (r < 97) begin
            return $urandom_range(9, 31);
        end
        return $urandom_range(wgm_pkg::MAX_MASK_LEN, wgm_pkg::MAX_MASK_LEN + 4);
    endfunction

    task automatic send_word(input logic [wgm_pkg::ACTION_W-1:0] act,
                             input logic [wgm_pkg::CHAR_W-1:0] ch);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(act, ch);
        sent_words++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_results.size() != 0);
    endtask

    // A mask, then one to three subjects built from it, mostly matching.
    task automatic run_glob(input int mlen);
        logic [wgm_pkg::CHAR_W-1:0] pat [$];
        logic [wgm_pkg::CHAR_W-1:0] subj [$];
        int                         nsubj;
        int                         idx;
        if ($urandom_range(0, 9) != 0) begin
            send_word(wgm_pkg::ACT_CLEAR, 16'($urandom_range(0, 65535)));
        end
        for (int i = 0; i < mlen; i++) begin
            pat.push_back(pick_char());
            send_word(wgm_pkg::ACT_APPEND, pat[i]);
        end
        nsubj = $urandom_range(1, 3);
        for (int s = 0; s < nsubj; s++) begin
            subj.delete();
            foreach (pat[i]) begin
                if (pat[i] == wgm_pkg::GLOB_STAR) begin
                    repeat ($urandom_range(0, 3)) subj.push_back(pick_char());
                end else if (pat[i] == wgm_pkg::GLOB_ANY) begin
                    subj.push_back(16'($urandom_range(0, 65535)));
                end else begin
                    subj.push_back(pat[i]);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: begin
                        if (subj.size() > 0) begin
                            idx = $urandom_range(0, subj.size() - 1);
                            subj[idx] = pick_char();
                        end
                    end
                    1: begin
                        if (subj.size() > 0) begin
                            void'(subj.pop_back());
                        end
                    end
                    default: begin
                        subj.push_back(pick_char());
                    end
                endcase
            end
            foreach (subj[i]) begin
                if ($urandom_range(0, 32) == 0) begin
                    send_word(wgm_pkg::ACT_APPEND, pick_char());
                end
                send_word(wgm_pkg::ACT_SUBJECT, subj[i]);
            end
            send_word(wgm_pkg::ACT_END, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(0, 1) == 0) begin
                send_word(2'($urandom_range(0, 3)), pick_char());
            end else begin
                send_word(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin : result_side
        int gap;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = rand_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(wgm_pkg::wgm_result_t'(m_tdata[1:0]));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int seq_count;
        int directed_words;
        seq_count = 0;
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= wgm_pkg::ACT_CLEAR;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty mask against the empty subject and a one-character subject.
        send_word(wgm_pkg::ACT_END, 16'hFFFF);
        send_word(wgm_pkg::ACT_SUBJECT, 16'h0000);
        send_word(wgm_pkg::ACT_END, 16'h0000);
        // A lone star matches the empty subject and any other.
        send_word(wgm_pkg::ACT_APPEND, wgm_pkg::GLOB_STAR);
        send_word(wgm_pkg::ACT_END, 16'h0000);
        send_word(wgm_pkg::ACT_SUBJECT, 16'hFFFF);
        send_word(wgm_pkg::ACT_SUBJECT, 16'h0000);
        send_word(wgm_pkg::ACT_END, 16'h0000);
        // Character zero and all-ones as literals, then a subject too long.
        send_word(wgm_pkg::ACT_CLEAR, 16'hFFFF);
        send_word(wgm_pkg::ACT_APPEND, 16'h0000);
        send_word(wgm_pkg::ACT_APPEND, wgm_pkg::GLOB_ANY);
        send_word(wgm_pkg::ACT_APPEND, 16'hFFFF);
        send_word(wgm_pkg::ACT_SUBJECT, 16'h0000);
        send_word(wgm_pkg::ACT_SUBJECT, 16'h5A5A);
        send_word(wgm_pkg::ACT_SUBJECT, 16'hFFFF);
        send_word(wgm_pkg::ACT_END, 16'h0000);
        send_word(wgm_pkg::ACT_SUBJECT, 16'h0000);
        send_word(wgm_pkg::ACT_SUBJECT, 16'h1234);
        send_word(wgm_pkg::ACT_SUBJECT, 16'hFFFF);
        send_word(wgm_pkg::ACT_SUBJECT, 16'hFFFF);
        send_word(wgm_pkg::ACT_END, 16'h0000);
        // The mask grows in the middle of a subject.
        send_word(wgm_pkg::ACT_CLEAR, 16'h0000);
        send_word(wgm_pkg::ACT_APPEND, 16'h0061);
        send_word(wgm_pkg::ACT_SUBJECT, 16'h0061);
        send_word(wgm_pkg::ACT_APPEND, wgm_pkg::GLOB_STAR);
        send_word(wgm_pkg::ACT_SUBJECT, 16'hAAAA);
        send_word(wgm_pkg::ACT_END, 16'h0000);
        wait_results();
        directed_words = sent_words;

        // A mask longer than the store, right at the start of the random part.
        run_glob(wgm_pkg::MAX_MASK_LEN + $urandom_range(1, 4));
        while (sent_words < directed_words + ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                calm = !calm;
            end
            if ($urandom_range(0, 99) < 15) begin
                send_noise();
            end else begin
                run_glob(pick_mask_len());
            end
            seq_count++;
            if (seq_count % 20 == 10) begin
                wait_results();
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_results.size() != 0) begin
            $error("%0d results never arrived.", sb.expected_results.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
